FILE: rtl/ndsb_pkg.sv
// ----------------------------------------------------------------------------
// ndsb_pkg
// Shared constants, codes and record types of the depth-sort buffer.
// ----------------------------------------------------------------------------
package ndsb_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DIST_W  = 32;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_EMIT_SLOT,
    ST_EMIT_NEW
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  alpha;
    logic        additive;
    logic [31:0] light;
    logic [31:0] fade;
    logic [15:0] lump;
    logic [15:0] translation;
    logic [15:0] time_frac;
    logic [31:0] rec_ref;
  } payload_t;

  typedef struct packed {
    op_e               opcode;
    logic [DIST_W-1:0] distance;
    payload_t          payload;
  } request_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    payload_t          payload;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DIST_W-1:0] wdist;
    payload_t          wdata;
    logic              dist_re;
    logic [IDX_W-1:0]  dist_raddr;
    logic              data_re;
    logic [IDX_W-1:0]  data_raddr;
  } mem_req_t;

  typedef struct packed {
    logic               busy;
    logic [ENTRIES-1:0] occupied;
  } status_t;

endpackage

FILE: rtl/ndsb_if.sv
// ----------------------------------------------------------------------------
// ndsb_in_if / ndsb_out_if
// Valid/ready channels for incoming commands and emitted draw records.
// ----------------------------------------------------------------------------
interface ndsb_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] distance;
  logic [1:0]  kind;
  logic [7:0]  alpha;
  logic        additive;
  logic [31:0] light;
  logic [31:0] fade;
  logic [15:0] lump_index;
  logic [15:0] translation;
  logic [15:0] time_frac;
  logic [31:0] record_ref;

  modport source (
    output valid, opcode, distance, kind, alpha, additive, light, fade,
           lump_index, translation, time_frac, record_ref,
    input  ready
  );
  modport sink (
    input  valid, opcode, distance, kind, alpha, additive, light, fade,
           lump_index, translation, time_frac, record_ref,
    output ready
  );
endinterface

interface ndsb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] emit_distance;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_alpha;
  logic        emit_additive;
  logic [31:0] emit_light;
  logic [31:0] emit_fade;
  logic [15:0] emit_lump;
  logic [15:0] emit_translation;
  logic [15:0] emit_time_frac;
  logic [31:0] emit_ref;
  logic        last_of_run;

  modport source (
    output valid, emit_distance, emit_kind, emit_alpha, emit_additive, emit_light,
           emit_fade, emit_lump, emit_translation, emit_time_frac, emit_ref,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, emit_distance, emit_kind, emit_alpha, emit_additive, emit_light,
           emit_fade, emit_lump, emit_translation, emit_time_frac, emit_ref,
           last_of_run,
    output ready
  );
endinterface

FILE: rtl/nearest_k_depth_sort_buffer_top.sv
// ----------------------------------------------------------------------------
// nearest_k_depth_sort_buffer_top
// Bounded depth-sort buffer for translucent draw records that, when full, emits
// the farthest of the stored entries and the new record.
// ----------------------------------------------------------------------------
// The block takes one command at a time. An insert with nonzero alpha scans
// the distance memory one slot per cycle, then writes the record into the
// lowest free slot or, when the buffer is full, emits the stored farthest
// entry if it is farther than the new record and the new record otherwise.
// A zero-alpha insert and a drain of an empty buffer end without a scan. A
// drain emits the stored records farthest first, each after a full scan of
// the distance memory; an emitted record waits while the output register
// still holds an untaken result. Results go through an output register, so
// the next command is taken while the last result still waits. The slot
// memories need no clearing after reset.
module nearest_k_depth_sort_buffer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ndsb_in_if.sink    in_i,
  ndsb_out_if.source out_o
);
  import ndsb_pkg::*;

  request_t          in_req;
  mem_req_t          mem_req;
  logic [DIST_W-1:0] dist_rdata;
  payload_t          data_rdata;
  logic              out_free;
  logic              emit_valid;
  result_t           emit;
  status_t           status;
  logic              out_valid_q;
  result_t           out_data_q;

  assign in_req.opcode              = op_e'(in_i.opcode);
  assign in_req.distance            = in_i.distance;
  assign in_req.payload.kind        = in_i.kind;
  assign in_req.payload.alpha       = in_i.alpha;
  assign in_req.payload.additive    = in_i.additive;
  assign in_req.payload.light       = in_i.light;
  assign in_req.payload.fade        = in_i.fade;
  assign in_req.payload.lump        = in_i.lump_index;
  assign in_req.payload.translation = in_i.translation;
  assign in_req.payload.time_frac   = in_i.time_frac;
  assign in_req.payload.rec_ref     = in_i.record_ref;

  ndsb_store u_store (
    .clk_i        (clk_i),
    .mem_i        (mem_req),
    .dist_rdata_o (dist_rdata),
    .data_rdata_o (data_rdata)
  );

  ndsb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_req_i     (in_req),
    .mem_o        (mem_req),
    .dist_rdata_i (dist_rdata),
    .data_rdata_i (data_rdata),
    .out_free_i   (out_free),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .status_o     (status)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) begin
      out_data_q <= emit;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.emit_distance    = out_data_q.distance;
  assign out_o.emit_kind        = out_data_q.payload.kind;
  assign out_o.emit_alpha       = out_data_q.payload.alpha;
  assign out_o.emit_additive    = out_data_q.payload.additive;
  assign out_o.emit_light       = out_data_q.payload.light;
  assign out_o.emit_fade        = out_data_q.payload.fade;
  assign out_o.emit_lump        = out_data_q.payload.lump;
  assign out_o.emit_translation = out_data_q.payload.translation;
  assign out_o.emit_time_frac   = out_data_q.payload.time_frac;
  assign out_o.emit_ref         = out_data_q.payload.rec_ref;
  assign out_o.last_of_run      = out_data_q.last;

  a_empty_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.opcode == OP_DRAIN) && (status.occupied == '0)
    |=> in_i.ready)
    else $error("drain of an empty buffer did not finish at once");

  a_zero_alpha_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.opcode == OP_INSERT) && (in_i.alpha == 8'd0)
    |=> in_i.ready && $stable(status.occupied))
    else $error("zero-alpha insert changed the buffer");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> !in_i.ready)
    else $error("input taken while a command is in progress");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid |-> out_free)
    else $error("result loaded over an untaken result");

endmodule

FILE: rtl/ndsb_store.sv
// ----------------------------------------------------------------------------
// ndsb_store
// Slot storage: a distance memory for the scan and a payload memory for the
// emitted record, both with one registered read port and one write port.
// ----------------------------------------------------------------------------
module ndsb_store (
  input  logic                      clk_i,
  input  ndsb_pkg::mem_req_t        mem_i,
  output logic [ndsb_pkg::DIST_W-1:0] dist_rdata_o,
  output ndsb_pkg::payload_t        data_rdata_o
);
  import ndsb_pkg::*;

  logic [DIST_W-1:0] dist_mem [ENTRIES];
  payload_t          data_mem [ENTRIES];
  logic [DIST_W-1:0] dist_rdata_q;
  payload_t          data_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      dist_mem[mem_i.waddr] <= mem_i.wdist;
      data_mem[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.dist_re) begin
      dist_rdata_q <= dist_mem[mem_i.dist_raddr];
    end
    if (mem_i.data_re) begin
      data_rdata_q <= data_mem[mem_i.data_raddr];
    end
  end

  assign dist_rdata_o = dist_rdata_q;
  assign data_rdata_o = data_rdata_q;

endmodule

FILE: rtl/ndsb_ctrl.sv
// ----------------------------------------------------------------------------
// ndsb_ctrl
// Command sequencer: holds the slot valid bits, scans the distance memory one
// slot per cycle for the lowest free slot and the farthest entry, then writes
// back or emits records.
// ----------------------------------------------------------------------------
module ndsb_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ndsb_pkg::request_t          in_req_i,
  output ndsb_pkg::mem_req_t          mem_o,
  input  logic [ndsb_pkg::DIST_W-1:0] dist_rdata_i,
  input  ndsb_pkg::payload_t          data_rdata_i,
  input  logic                        out_free_i,
  output logic                        emit_valid_o,
  output ndsb_pkg::result_t           emit_o,
  output ndsb_pkg::status_t           status_o
);
  import ndsb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e             state_q, state_d;
  request_t           req_q, req_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic               best_found_q, best_found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [DIST_W-1:0]  best_d_q, best_d_d;
  logic               free_found_q, free_found_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;

  logic               pend_occ;
  logic               take_best;
  logic               take_free;
  logic [ENTRIES-1:0] best_mask;
  logic [ENTRIES-1:0] valid_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      pend_q       <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      pend_q       <= pend_d;
      best_found_q <= best_found_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_d_q   <= best_d_d;
    free_idx_q <= free_idx_d;
  end

  assign pend_occ   = valid_q[pend_idx_q];
  assign take_best  = pend_q && pend_occ && (!best_found_q || (dist_rdata_i > best_d_q));
  assign take_free  = pend_q && !pend_occ && !free_found_q;
  assign best_mask  = ENTRIES'(1) << best_idx_q;
  assign valid_left = valid_q & ~best_mask;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d_d     = best_d_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;

    mem_o            = '0;
    mem_o.waddr      = best_idx_q;
    mem_o.wdist      = req_q.distance;
    mem_o.wdata      = req_q.payload;
    mem_o.dist_raddr = idx_q;
    mem_o.data_raddr = best_idx_q;

    in_ready_o       = 1'b0;
    emit_valid_o     = 1'b0;
    emit_o.distance  = best_d_q;
    emit_o.payload   = data_rdata_i;
    emit_o.last      = 1'b1;

    if (state_q == ST_SCAN || state_q == ST_SCAN_END) begin
      if (take_best) begin
        best_found_d = 1'b1;
        best_idx_d   = pend_idx_q;
        best_d_d     = dist_rdata_i;
      end
      if (take_free) begin
        free_found_d = 1'b1;
        free_idx_d   = pend_idx_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d        = in_req_i;
          idx_d        = '0;
          pend_d       = 1'b0;
          best_found_d = 1'b0;
          free_found_d = 1'b0;
          if (in_req_i.opcode == OP_DRAIN) begin
            state_d = (valid_q != '0) ? ST_SCAN : ST_IDLE;
          end else begin
            state_d = (in_req_i.payload.alpha == 8'd0) ? ST_IDLE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_o.dist_re = 1'b1;
        pend_d        = 1'b1;
        pend_idx_d    = idx_q;
        if (idx_q == LAST_IDX) begin
          state_d = ST_SCAN_END;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCAN_END: begin
        pend_d  = 1'b0;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (req_q.opcode == OP_DRAIN) begin
          mem_o.data_re = 1'b1;
          state_d       = ST_EMIT_SLOT;
        end else if (free_found_q) begin
          mem_o.we              = 1'b1;
          mem_o.waddr           = free_idx_q;
          valid_d[free_idx_q]   = 1'b1;
          state_d               = ST_IDLE;
        end else if (best_d_q > req_q.distance) begin
          mem_o.data_re = 1'b1;
          state_d       = ST_EMIT_SLOT;
        end else begin
          state_d = ST_EMIT_NEW;
        end
      end
      ST_EMIT_SLOT: begin
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          if (req_q.opcode == OP_DRAIN) begin
            emit_o.last = (valid_left == '0);
            valid_d     = valid_left;
            if (valid_left == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d        = '0;
              pend_d       = 1'b0;
              best_found_d = 1'b0;
              free_found_d = 1'b0;
              state_d      = ST_SCAN;
            end
          end else begin
            mem_o.we = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_EMIT_NEW: begin
        emit_o.distance = req_q.distance;
        emit_o.payload  = req_q.payload;
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign status_o.busy     = (state_q != ST_IDLE);
  assign status_o.occupied = valid_q;

endmodule
